FILE: sv/ddr_pkg.sv
package ddr_pkg;

  localparam int RX_BUFFER_SIZE_DEF = 64;
  localparam int HDR_BYTES = 5;
  localparam int FIRST_DATA = 3;
  localparam int MIN_LENGTH = 3;

  localparam logic [7:0] PREAMBLE_FIRST_RST = 8'h5A;
  localparam logic [7:0] PREAMBLE_SECOND_RST = 8'hA5;
  localparam logic [7:0] CMD_WRITE = 8'h82;
  localparam logic [7:0] CMD_READ = 8'h83;
  localparam logic [15:0] VP_SCREEN = 16'h0014;
  localparam logic [7:0] CHAR_O = 8'h4F;
  localparam logic [7:0] CHAR_K = 8'h4B;

  localparam logic REG_PREAMBLE_FIRST = 1'b0;
  localparam logic REG_PREAMBLE_SECOND = 1'b1;

  typedef enum logic [1:0] {
    KIND_ACK = 2'd0,
    KIND_DATA = 2'd1,
    KIND_SCREEN = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_PRE1 = 2'd1,
    PH_PRE2 = 2'd2,
    PH_BODY = 2'd3
  } phase_t;

  typedef enum logic [1:0] {
    ST_RX = 2'd0,
    ST_FIN = 2'd1,
    ST_RD = 2'd2,
    ST_OUT = 2'd3
  } state_t;

endpackage

FILE: sv/ddr_in_if.sv
interface ddr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] rx_byte;
  logic       abort;

  modport source (output valid, output rx_byte, output abort, input ready);
  modport sink (input valid, input rx_byte, input abort, output ready);
endinterface

FILE: sv/ddr_out_if.sv
interface ddr_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [15:0] vp_address;
  logic [7:0]  word_count;
  logic [15:0] data_value;
  logic        has_data;
  logic        last;

  modport source (output valid, output kind, output vp_address, output word_count,
                  output data_value, output has_data, output last, input ready);
  modport sink (input valid, input kind, input vp_address, input word_count,
                input data_value, input has_data, input last, output ready);
endinterface

FILE: sv/display_datagram_receiver.sv
// Receiver for length-prefixed datagrams from a touch display serial link. Each
// received byte request is accepted while the block is in its receive state;
// payload bytes go to a single-port buffer memory and the first five are also
// kept in a small header register. After the final byte of a frame, a classify
// state decides its results and input is held off until all results of the
// frame are delivered. A single result waits in the output state for the sink;
// each data byte of a read-variable frame passes a buffer read state and then
// an output state that waits for the sink, as the buffer has one read port.
// Bytes arriving between frames or inside a frame are accepted alike, and
// the block needs no clearing pass after reset.
module display_datagram_receiver #(
  parameter int RX_BUFFER_SIZE = ddr_pkg::RX_BUFFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ddr_in_if.sink      in_chan,
  ddr_out_if.source   out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);
  import ddr_pkg::*;

  localparam int ADDR_W = $clog2(RX_BUFFER_SIZE);
  localparam int CNT_W = $clog2(RX_BUFFER_SIZE + 1);
  localparam logic [7:0] LEN_MAX = 8'(RX_BUFFER_SIZE);

  logic [7:0] pre1_r, pre2_r;

  phase_t            phase_r, phase_nxt;
  state_t            state_r, state_nxt;
  logic [CNT_W-1:0]  frame_len_r, frame_len_nxt;
  logic [CNT_W-1:0]  bytes_seen_r, bytes_seen_nxt;
  logic [7:0]        cmd_r, cmd_nxt;
  logic [7:0]        hdr_r [HDR_BYTES];
  logic [7:0]        hdr_nxt [HDR_BYTES];
  logic [ADDR_W-1:0] rd_idx_r, rd_idx_nxt;
  logic [7:0]        rd_q_r;

  kind_t             kind_r, kind_nxt;
  logic [15:0]       dv_r, dv_nxt;
  logic              has_data_r, has_data_nxt;
  logic              last_r, last_nxt;
  logic              use_mem_r, use_mem_nxt;

  logic [7:0]        mem [RX_BUFFER_SIZE];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_waddr;

  logic              acc;
  logic [CNT_W-1:0]  bs_inc;
  logic [CNT_W-1:0]  plen;
  logic [CNT_W-1:0]  pidx;
  logic [15:0]       vp;

  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_PREAMBLE_SECOND) ? {24'd0, pre2_r} : {24'd0, pre1_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pre1_r <= PREAMBLE_FIRST_RST;
      pre2_r <= PREAMBLE_SECOND_RST;
    end else if (psel && penable && pwrite && pready) begin
      if (paddr[2] == REG_PREAMBLE_FIRST) begin
        pre1_r <= pwdata[7:0];
      end else begin
        pre2_r <= pwdata[7:0];
      end
    end
  end

  assign acc = in_chan.valid && in_chan.ready;
  assign bs_inc = bytes_seen_r + CNT_W'(1);
  assign plen = frame_len_r - CNT_W'(1);
  assign pidx = bytes_seen_r - CNT_W'(1);
  assign vp = {hdr_r[0], hdr_r[1]};

  assign in_chan.ready = (state_r == ST_RX);
  assign out_chan.valid = (state_r == ST_OUT);
  assign out_chan.kind = kind_r;
  assign out_chan.vp_address = vp;
  assign out_chan.word_count = hdr_r[2];
  assign out_chan.data_value = use_mem_r ? {8'd0, rd_q_r} : dv_r;
  assign out_chan.has_data = has_data_r;
  assign out_chan.last = last_r;

  assign mem_we = acc && !in_chan.abort && (phase_r == PH_BODY) && (bytes_seen_r != '0);
  assign mem_waddr = pidx[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= in_chan.rx_byte;
    end
    if (state_r == ST_RD) begin
      rd_q_r <= mem[rd_idx_r];
    end
  end

  always_comb begin
    phase_nxt = phase_r;
    state_nxt = state_r;
    frame_len_nxt = frame_len_r;
    bytes_seen_nxt = bytes_seen_r;
    cmd_nxt = cmd_r;
    hdr_nxt = hdr_r;
    rd_idx_nxt = rd_idx_r;
    kind_nxt = kind_r;
    dv_nxt = dv_r;
    has_data_nxt = has_data_r;
    last_nxt = last_r;
    use_mem_nxt = use_mem_r;
    unique case (state_r)
      ST_RX: begin
        if (acc) begin
          if (in_chan.abort) begin
            phase_nxt = PH_IDLE;
            bytes_seen_nxt = '0;
          end else begin
            unique case (phase_r)
              PH_IDLE: begin
                if (in_chan.rx_byte == pre1_r) begin
                  phase_nxt = PH_PRE1;
                end
              end
              PH_PRE1: begin
                phase_nxt = (in_chan.rx_byte == pre2_r) ? PH_PRE2 : PH_IDLE;
              end
              PH_PRE2: begin
                bytes_seen_nxt = '0;
                frame_len_nxt = CNT_W'(in_chan.rx_byte);
                for (int i = 0; i < HDR_BYTES; i++) begin
                  hdr_nxt[i] = 8'd0;
                end
                if (in_chan.rx_byte >= 8'(MIN_LENGTH) && in_chan.rx_byte <= LEN_MAX) begin
                  phase_nxt = PH_BODY;
                end else begin
                  phase_nxt = PH_IDLE;
                end
              end
              PH_BODY: begin
                if (bytes_seen_r == '0) begin
                  cmd_nxt = in_chan.rx_byte;
                end else begin
                  for (int i = 0; i < HDR_BYTES; i++) begin
                    if (pidx == CNT_W'(i)) begin
                      hdr_nxt[i] = in_chan.rx_byte;
                    end
                  end
                end
                bytes_seen_nxt = bs_inc;
                if (bs_inc >= frame_len_r) begin
                  phase_nxt = PH_IDLE;
                  bytes_seen_nxt = '0;
                  state_nxt = ST_FIN;
                end
              end
              default: phase_nxt = PH_IDLE;
            endcase
          end
        end
      end
      ST_FIN: begin
        last_nxt = 1'b1;
        use_mem_nxt = 1'b0;
        dv_nxt = 16'd0;
        has_data_nxt = 1'b0;
        kind_nxt = KIND_DATA;
        if (cmd_r == CMD_WRITE && hdr_r[0] == CHAR_O && hdr_r[1] == CHAR_K) begin
          kind_nxt = KIND_ACK;
          state_nxt = ST_OUT;
        end else if (cmd_r != CMD_READ) begin
          state_nxt = ST_RX;
        end else if (vp == VP_SCREEN) begin
          kind_nxt = KIND_SCREEN;
          dv_nxt = {hdr_r[3], hdr_r[4]};
          has_data_nxt = (plen >= CNT_W'(HDR_BYTES));
          state_nxt = ST_OUT;
        end else if (plen <= CNT_W'(FIRST_DATA)) begin
          state_nxt = ST_OUT;
        end else begin
          has_data_nxt = 1'b1;
          use_mem_nxt = 1'b1;
          rd_idx_nxt = ADDR_W'(FIRST_DATA);
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        last_nxt = (CNT_W'(rd_idx_r) + CNT_W'(1) == plen);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (out_chan.ready) begin
          if (last_r) begin
            state_nxt = ST_RX;
          end else begin
            rd_idx_nxt = rd_idx_r + ADDR_W'(1);
            state_nxt = ST_RD;
          end
        end
      end
      default: state_nxt = ST_RX;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      state_r <= ST_RX;
      frame_len_r <= '0;
      bytes_seen_r <= '0;
      cmd_r <= 8'd0;
    end else begin
      phase_r <= phase_nxt;
      state_r <= state_nxt;
      frame_len_r <= frame_len_nxt;
      bytes_seen_r <= bytes_seen_nxt;
      cmd_r <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hdr_r <= hdr_nxt;
    rd_idx_r <= rd_idx_nxt;
    kind_r <= kind_nxt;
    dv_r <= dv_nxt;
    has_data_r <= has_data_nxt;
    last_r <= last_nxt;
    use_mem_r <= use_mem_nxt;
  end

endmodule

FILE: bench/ddr_frame_check.sv
`timescale 1ns / 1ps

module ddr_frame_check
  import ddr_pkg::*;
#(
  parameter int RX_BUF = RX_BUFFER_SIZE_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  ddr_in_if           in_chan,
  ddr_out_if          out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic        pready,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output int          n_errors,
  output int          n_pending,
  output int          n_predicted
);

  typedef struct packed {
    kind_t       kind;
    logic [15:0] vp_address;
    logic [7:0]  word_count;
    logic [15:0] data_value;
    logic        has_data;
    logic        last;
  } result_t;

  result_t    pending_results[$];
  phase_t     rx_phase;
  logic [7:0] frame_len;
  logic [7:0] body_count;
  logic [7:0] cmd_byte;
  logic [7:0] payload[RX_BUF];
  logic       link_up;
  logic [7:0] pre_first;
  logic [7:0] pre_second;
  int         mismatches = 0;
  int         predicted = 0;

  initial begin
    n_errors = 0;
    n_pending = 0;
    n_predicted = 0;
  end

  function automatic void reset_model();
    pending_results.delete();
    rx_phase = PH_IDLE;
    frame_len = 8'd0;
    body_count = 8'd0;
    cmd_byte = 8'd0;
    link_up = 1'b0;
    pre_first = PREAMBLE_FIRST_RST;
    pre_second = PREAMBLE_SECOND_RST;
  endfunction

  function automatic logic [7:0] payload_at(int idx, int plen);
    if (idx >= plen || idx >= RX_BUF) return 8'h00;
    return payload[idx];
  endfunction

  function automatic void push_result(kind_t k, logic [15:0] vp, logic [7:0] wc,
                                      logic [15:0] dv, logic hd, logic lst);
    result_t r;
    r.kind = k;
    r.vp_address = vp;
    r.word_count = wc;
    r.data_value = dv;
    r.has_data = hd;
    r.last = lst;
    pending_results.push_back(r);
    predicted++;
  endfunction

  function automatic void classify_frame();
    int          plen;
    logic [15:0] vp;
    logic [7:0]  wc;
    plen = int'(frame_len) - 1;
    vp = {payload_at(0, plen), payload_at(1, plen)};
    wc = payload_at(2, plen);
    link_up = 1'b1;
    if (cmd_byte == CMD_WRITE && payload_at(0, plen) == CHAR_O
        && payload_at(1, plen) == CHAR_K) begin
      push_result(KIND_ACK, vp, wc, 16'd0, 1'b0, 1'b1);
    end else if (cmd_byte == CMD_READ) begin
      if (vp == VP_SCREEN) begin
        push_result(KIND_SCREEN, vp, wc, {payload_at(3, plen), payload_at(4, plen)},
                    plen >= HDR_BYTES, 1'b1);
      end else if (plen <= FIRST_DATA) begin
        push_result(KIND_DATA, vp, wc, 16'd0, 1'b0, 1'b1);
      end else begin
        for (int i = FIRST_DATA; i < plen; i++) begin
          push_result(KIND_DATA, vp, wc, {8'd0, payload_at(i, plen)}, 1'b1, i + 1 == plen);
        end
      end
    end
  endfunction

  function automatic void track_rx_byte(logic [7:0] b, logic ab);
    if (ab) begin
      rx_phase = PH_IDLE;
      body_count = 8'd0;
      return;
    end
    case (rx_phase)
      PH_IDLE: begin
        if (b == pre_first) rx_phase = PH_PRE1;
      end
      PH_PRE1: begin
        rx_phase = (b == pre_second) ? PH_PRE2 : PH_IDLE;
      end
      PH_PRE2: begin
        frame_len = b;
        body_count = 8'd0;
        rx_phase = (b >= MIN_LENGTH && b <= RX_BUF) ? PH_BODY : PH_IDLE;
      end
      default: begin
        if (body_count == 8'd0) cmd_byte = b;
        else if (int'(body_count) - 1 < RX_BUF) payload[int'(body_count) - 1] = b;
        body_count = body_count + 8'd1;
        if (body_count >= frame_len) begin
          classify_frame();
          rx_phase = PH_IDLE;
          body_count = 8'd0;
        end
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [15:0] want, logic [15:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      mismatches++;
    end
  endfunction

  function automatic void compare_result();
    result_t want;
    if (pending_results.size() == 0) begin
      $error("result with no request behind it: kind %0h vp_address %0h data_value %0h",
             out_chan.kind, out_chan.vp_address, out_chan.data_value);
      mismatches++;
      return;
    end
    want = pending_results.pop_front();
    check_field("kind", 16'(want.kind), 16'(out_chan.kind));
    check_field("vp_address", want.vp_address, out_chan.vp_address);
    check_field("word_count", 16'(want.word_count), 16'(out_chan.word_count));
    check_field("data_value", want.data_value, out_chan.data_value);
    check_field("has_data", 16'(want.has_data), 16'(out_chan.has_data));
    check_field("last", 16'(want.last), 16'(out_chan.last));
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      reset_model();
    end else begin
      if (psel && penable && pwrite && pready) begin
        if (paddr[2] == REG_PREAMBLE_SECOND) pre_second = pwdata[7:0];
        else pre_first = pwdata[7:0];
      end
      if (in_chan.valid && in_chan.ready) track_rx_byte(in_chan.rx_byte, in_chan.abort);
      if (out_chan.valid && out_chan.ready) compare_result();
    end
    n_errors <= mismatches;
    n_pending <= pending_results.size();
    n_predicted <= predicted;
  end

endmodule

FILE: bench/tb_display_datagram_receiver.sv
`timescale 1ns / 1ps

module tb_display_datagram_receiver;
  import ddr_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  localparam int LONG_HOLD = 300;
  localparam int SETTLE = 20;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  ddr_in_if  in_if();
  ddr_out_if out_if();

  int         n_errors;
  int         n_pending;
  int         n_predicted;
  int         in_count = 0;
  int         cycles = 0;
  bit         src_idle = 1'b1;
  bit         snk_idle = 1'b1;
  bit         hold_req = 1'b0;
  logic [7:0] cur_first = PREAMBLE_FIRST_RST;
  logic [7:0] cur_second = PREAMBLE_SECOND_RST;
  logic [7:0] body_q[$];

  display_datagram_receiver DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_if),
    .out_chan (out_if),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  ddr_frame_check frame_check (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_if),
    .out_chan    (out_if),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .pready      (pready),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .n_errors    (n_errors),
    .n_pending   (n_pending),
    .n_predicted (n_predicted)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  task automatic put_byte(input logic [7:0] b, input logic ab);
    int gap;
    gap = src_idle ? $urandom_range(0, 10) : 0;
    if (gap > 0) begin
      in_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.rx_byte <= b;
    in_if.abort <= ab;
    @(posedge clk);
    while (!in_if.ready) @(posedge clk);
    in_count++;
  endtask

  task automatic put_frame(input logic [7:0] len, input logic [7:0] cmd, input bit may_cut);
    logic [7:0] stream[$];
    int         cut;
    stream = {cur_first, cur_second, len, cmd};
    foreach (body_q[i]) stream.push_back(body_q[i]);
    cut = (may_cut && $urandom_range(0, 11) == 0) ? $urandom_range(0, stream.size() - 1) : -1;
    foreach (stream[i]) begin
      if (i == cut) put_byte(8'($urandom), 1'b1);
      put_byte(stream[i], 1'b0);
    end
  endtask

  task automatic random_frame();
    int         sel;
    int         n;
    logic [7:0] cmd;
    logic [7:0] len;
    sel = $urandom_range(0, 99);
    body_q.delete();
    if (sel < 10) begin
      cmd = CMD_WRITE;
      body_q = {CHAR_O, CHAR_K};
      n = $urandom_range(0, 3);
    end else if (sel < 18) begin
      cmd = CMD_WRITE;
      n = $urandom_range(2, 5);
    end else if (sel < 33) begin
      cmd = CMD_READ;
      body_q = {VP_SCREEN[15:8], VP_SCREEN[7:0], 8'($urandom)};
      n = $urandom_range(0, 2);
    end else if (sel < 73) begin
      cmd = CMD_READ;
      body_q = {8'($urandom), 8'($urandom), 8'($urandom)};
      n = ($urandom_range(0, 7) == 0) ? $urandom_range(7, 60) : $urandom_range(0, 6);
    end else if (sel < 85) begin
      cmd = 8'($urandom);
      n = $urandom_range(2, 6);
    end else begin
      repeat ($urandom_range(1, 4)) put_byte(8'($urandom), $urandom_range(0, 9) == 0);
      return;
    end
    repeat (n) body_q.push_back(8'($urandom));
    len = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'(body_q.size() + 1);
    put_frame(len, cmd, 1'b1);
  endtask

  task automatic drain();
    in_if.valid <= 1'b0;
    @(posedge clk);
    while (n_pending != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic write_reg(input logic sel, input logic [7:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {sel, 2'b00};
    pwdata <= {24'd0, val};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
  endtask

  task automatic set_preambles(input logic [7:0] first, input logic [7:0] second);
    put_byte(8'h00, 1'b1);
    drain();
    write_reg(REG_PREAMBLE_FIRST, first);
    write_reg(REG_PREAMBLE_SECOND, second);
    cur_first = first;
    cur_second = second;
  endtask

  task automatic random_until(input int target);
    while (in_count < target) random_frame();
  endtask

  // A long hold-off on the result side lets a long read frame back up into the input.
  initial begin
    int stall;
    wait (rst_n === 1'b1);
    forever begin
      if (hold_req) begin
        hold_req = 1'b0;
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end
      stall = snk_idle ? $urandom_range(0, 10) : 0;
      if (stall > 0) begin
        out_if.ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_if.ready <= 1'b1;
      @(posedge clk);
      while (!out_if.valid) @(posedge clk);
    end
  end

  initial begin
    rst_n = 1'b0;
    in_if.valid = 1'b0;
    in_if.rx_byte = 8'd0;
    in_if.abort = 1'b0;
    out_if.ready = 1'b0;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = 3'd0;
    pwdata = 32'd0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    body_q = {CHAR_O, CHAR_K};
    put_frame(8'd3, CMD_WRITE, 1'b0);
    body_q = {VP_SCREEN[15:8], VP_SCREEN[7:0], 8'h07, 8'h12, 8'h34};
    put_frame(8'd6, CMD_READ, 1'b0);
    body_q = {8'h12, 8'h34};
    put_frame(8'd3, CMD_READ, 1'b0);
    body_q.delete();
    put_frame(8'd2, CMD_READ, 1'b0);
    put_frame(8'd65, CMD_WRITE, 1'b0);
    put_byte(cur_first, 1'b0);
    put_byte(cur_first, 1'b0);
    put_byte(cur_second, 1'b0);
    put_byte(8'd3, 1'b0);
    put_byte(CMD_WRITE, 1'b0);
    put_byte(CHAR_O, 1'b0);
    put_byte(CHAR_K, 1'b0);
    put_byte(cur_first, 1'b0);
    put_byte(cur_second, 1'b0);
    put_byte(8'd3, 1'b0);
    put_byte(8'hFF, 1'b1);
    body_q = {CHAR_O, CHAR_O};
    put_frame(8'd3, CMD_WRITE, 1'b0);
    random_until(in_count + 5);

    src_idle = 1'b0;
    set_preambles(8'h00, 8'hFF);
    random_until(in_count + 5);

    src_idle = 1'b1;
    snk_idle = 1'b0;
    set_preambles(8'hFF, 8'h00);
    hold_req = 1'b1;
    body_q = {8'h10, 8'h00, 8'd14};
    repeat (28) body_q.push_back(8'($urandom));
    put_frame(8'd32, CMD_READ, 1'b0);
    random_until(in_count + 5);

    src_idle = 1'b0;
    set_preambles(8'($urandom), 8'($urandom));
    random_until(in_count + 5);

    src_idle = 1'b1;
    snk_idle = 1'b1;
    set_preambles(PREAMBLE_FIRST_RST, PREAMBLE_SECOND_RST);
    while (in_count < 120) random_frame();

    drain();
    $display("Sent %0d bytes under five preamble settings, with and without idle gaps.",
             in_count);
    $display("Checked %0d results, including one long read frame under back-pressure.",
             n_predicted);
    if (n_errors == 0 && n_pending == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
